### rtl/lcd_controller_register_file_unit_assert.svh
// Assertion macros for the LCD register file.
// Used by lcd_controller_register_file_unit; needs a clock named clk and a reset named rst.
`ifndef LCD_CONTROLLER_REGISTER_FILE_UNIT_ASSERT_SVH
`define LCD_CONTROLLER_REGISTER_FILE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LCDRF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcdrf assertion failed");
// next-cycle implication
`define LCDRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcdrf assertion failed");
`else
`define LCDRF_ASSERT_NOW(lbl, ante, cons)
`define LCDRF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/lcdrf_pkg.sv
// Shared types and register offsets for the LCD register file.
// No dependencies.
package lcdrf_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [27:0] ref_point_t;

  localparam logic REQ_WRITE = 1'b1;

  localparam byte_t ADDR_DISPCNT_LO  = 8'h00;
  localparam byte_t ADDR_DISPCNT_HI  = 8'h01;
  localparam byte_t ADDR_GREEN_SWAP  = 8'h02;
  localparam byte_t ADDR_DISPSTAT    = 8'h04;
  localparam byte_t ADDR_VCOMPARE    = 8'h05;
  localparam byte_t ADDR_VCOUNT      = 8'h06;
  localparam byte_t ADDR_BGCNT_FIRST = 8'h08;
  localparam byte_t ADDR_BGCNT_LAST  = 8'h0F;
  localparam byte_t ADDR_SCROLL_FIRST = 8'h10;
  localparam byte_t ADDR_SCROLL_LAST = 8'h1F;
  localparam byte_t ADDR_AFF2_FIRST  = 8'h20;
  localparam byte_t ADDR_AFF2_LAST   = 8'h27;
  localparam byte_t ADDR_REF2_FIRST  = 8'h28;
  localparam byte_t ADDR_REF2_LAST   = 8'h2F;
  localparam byte_t ADDR_AFF3_FIRST  = 8'h30;
  localparam byte_t ADDR_AFF3_LAST   = 8'h37;
  localparam byte_t ADDR_REF3_FIRST  = 8'h38;
  localparam byte_t ADDR_REF3_LAST   = 8'h3F;
  localparam byte_t ADDR_WINBND_FIRST = 8'h40;
  localparam byte_t ADDR_WINBND_LAST = 8'h47;
  localparam byte_t ADDR_WININ_0     = 8'h48;
  localparam byte_t ADDR_WININ_1     = 8'h49;
  localparam byte_t ADDR_WINOUT      = 8'h4A;
  localparam byte_t ADDR_WINOBJ      = 8'h4B;
  localparam byte_t ADDR_MOSAIC_LO   = 8'h4C;
  localparam byte_t ADDR_MOSAIC_HI   = 8'h4D;
  localparam byte_t ADDR_BLEND_LO    = 8'h50;
  localparam byte_t ADDR_BLEND_HI    = 8'h51;
  localparam byte_t ADDR_BLEND_EVA   = 8'h52;
  localparam byte_t ADDR_BLEND_EVB   = 8'h53;
  localparam byte_t ADDR_BLEND_EVY   = 8'h54;

endpackage

### rtl/lcd_controller_register_file_unit.sv
// Byte-wide register file of a tile/bitmap LCD controller: decode, storage, read-back.
// Depends on lcdrf_pkg and lcd_controller_register_file_unit_assert.svh.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  request | in_valid/in_ready, req_type, addr_offset, write_data,  | in
//          | in_vblank, in_hblank, line_match, line_count         |
//  result  | out_valid/out_ready, read_data                       | out
//
// One access per cycle sustained while out_ready is high; after the request transfer the
// access passes through the input register, then the result register.
// Register writes and read decode happen as the access moves into the result register.
// Synchronous reset clears every register field and both valid flags.
// A stalled result holds the input register; in_ready drops only when both are full
// and out_ready is low.
`include "lcd_controller_register_file_unit_assert.svh"

module lcd_controller_register_file_unit
  import lcdrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] addr_offset,
  input  logic [7:0] write_data,
  input  logic       in_vblank,
  input  logic       in_hblank,
  input  logic       line_match,
  input  logic [7:0] line_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data
);

  // input register
  logic       s1_valid;
  logic       s1_wr;
  byte_t      s1_addr;
  byte_t      s1_data;
  logic       s1_vblank;
  logic       s1_hblank;
  logic       s1_match;
  byte_t      s1_line;

  // register fields
  logic [15:0] display_control;
  logic        outside_window_enable;
  logic        green_swap_flag;
  logic [2:0]  status_irq_enables;
  logic [7:0]  vcount_compare;
  logic [15:0] layer_control [4];
  logic [8:0]  scroll_offset [8];
  logic [15:0] affine_matrix [8];
  ref_point_t  reference_point [4];
  ref_point_t  reference_latch [4];
  logic [7:0]  window_bound [8];
  logic [5:0]  window_layer_mask [4];
  logic [3:0]  mosaic_size [4];
  logic [13:0] blend_targets_mode;
  logic [4:0]  blend_coefficient [3];

  logic        s1_adv;
  logic        wr_commit;
  logic [1:0]  layer_idx;
  logic [15:0] layer_next;
  logic [2:0]  scroll_idx;
  logic [2:0]  affine_idx;
  logic [15:0] affine_next;
  logic [1:0]  ref_idx;
  ref_point_t  ref_next;
  logic [1:0]  coef_idx;
  byte_t       rd_mux;

  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign wr_commit = s1_adv && (s1_wr == REQ_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_wr     <= req_type;
      s1_addr   <= addr_offset;
      s1_data   <= write_data;
      s1_vblank <= in_vblank;
      s1_hblank <= in_hblank;
      s1_match  <= line_match;
      s1_line   <= line_count;
    end
  end

  // field indexes taken straight from the offset bits
  assign layer_idx  = s1_addr[2:1];
  assign scroll_idx = s1_addr[3:1];
  assign affine_idx = {s1_addr[4], s1_addr[2:1]};
  assign ref_idx    = {s1_addr[4], s1_addr[2]};
  assign coef_idx   = 2'(s1_addr[1:0] - 2'd2);

  always_comb begin
    layer_next = layer_control[layer_idx];
    if (s1_addr[0]) layer_next[15:8] = s1_data;
    else            layer_next[7:0]  = s1_data;
    // wrap bit exists only on the affine layers
    if (!layer_idx[1]) layer_next[13] = 1'b0;

    affine_next = affine_matrix[affine_idx];
    if (s1_addr[0]) affine_next[15:8] = s1_data;
    else            affine_next[7:0]  = s1_data;

    ref_next = reference_point[ref_idx];
    case (s1_addr[1:0])
      2'd0:    ref_next[7:0]   = s1_data;
      2'd1:    ref_next[15:8]  = s1_data;
      2'd2:    ref_next[23:16] = s1_data;
      default: ref_next[27:24] = s1_data[3:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_control       <= '0;
      outside_window_enable <= 1'b0;
      green_swap_flag       <= 1'b0;
      status_irq_enables    <= '0;
      vcount_compare        <= '0;
      blend_targets_mode    <= '0;
      for (int i = 0; i < 4; i++) begin
        layer_control[i]     <= '0;
        reference_point[i]   <= '0;
        reference_latch[i]   <= '0;
        window_layer_mask[i] <= '0;
        mosaic_size[i]       <= '0;
      end
      for (int i = 0; i < 8; i++) begin
        scroll_offset[i] <= '0;
        affine_matrix[i] <= '0;
        window_bound[i]  <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        blend_coefficient[i] <= '0;
      end
    end else if (wr_commit) begin
      unique case (s1_addr) inside
        ADDR_DISPCNT_LO: display_control[7:0] <= s1_data;
        ADDR_DISPCNT_HI: begin
          display_control[15:8] <= s1_data;
          outside_window_enable <= |s1_data[7:5];
        end
        ADDR_GREEN_SWAP: green_swap_flag <= s1_data[0];
        ADDR_DISPSTAT:   status_irq_enables <= s1_data[5:3];
        ADDR_VCOMPARE:   vcount_compare <= s1_data;
        [ADDR_BGCNT_FIRST:ADDR_BGCNT_LAST]: layer_control[layer_idx] <= layer_next;
        [ADDR_SCROLL_FIRST:ADDR_SCROLL_LAST]: begin
          if (s1_addr[0]) scroll_offset[scroll_idx][8]   <= s1_data[0];
          else            scroll_offset[scroll_idx][7:0] <= s1_data;
        end
        [ADDR_AFF2_FIRST:ADDR_AFF2_LAST],
        [ADDR_AFF3_FIRST:ADDR_AFF3_LAST]: affine_matrix[affine_idx] <= affine_next;
        [ADDR_REF2_FIRST:ADDR_REF2_LAST],
        [ADDR_REF3_FIRST:ADDR_REF3_LAST]: begin
          reference_point[ref_idx] <= ref_next;
          reference_latch[ref_idx] <= ref_next;
        end
        [ADDR_WINBND_FIRST:ADDR_WINBND_LAST]: window_bound[s1_addr[2:0]] <= s1_data;
        ADDR_WININ_0: window_layer_mask[0] <= s1_data[5:0];
        ADDR_WININ_1: window_layer_mask[1] <= s1_data[5:0];
        ADDR_WINOUT:  window_layer_mask[3] <= s1_data[5:0];
        ADDR_WINOBJ:  window_layer_mask[2] <= s1_data[5:0];
        ADDR_MOSAIC_LO, ADDR_MOSAIC_HI: begin
          mosaic_size[{s1_addr[0], 1'b0}] <= s1_data[3:0];
          mosaic_size[{s1_addr[0], 1'b1}] <= s1_data[7:4];
        end
        ADDR_BLEND_LO: blend_targets_mode[7:0]  <= s1_data;
        ADDR_BLEND_HI: blend_targets_mode[13:8] <= s1_data[5:0];
        ADDR_BLEND_EVA, ADDR_BLEND_EVB, ADDR_BLEND_EVY:
          blend_coefficient[coef_idx] <= s1_data[4:0];
        default: ;
      endcase
    end
  end

  // read decode; write-only and unmapped offsets give zero
  always_comb begin
    unique case (s1_addr) inside
      ADDR_DISPCNT_LO: rd_mux = display_control[7:0];
      ADDR_DISPCNT_HI: rd_mux = display_control[15:8];
      ADDR_GREEN_SWAP: rd_mux = {7'd0, green_swap_flag};
      ADDR_DISPSTAT:   rd_mux = {2'd0, status_irq_enables, s1_match, s1_hblank, s1_vblank};
      ADDR_VCOMPARE:   rd_mux = vcount_compare;
      ADDR_VCOUNT:     rd_mux = s1_line;
      [ADDR_BGCNT_FIRST:ADDR_BGCNT_LAST]:
        rd_mux = s1_addr[0] ? layer_control[layer_idx][15:8] : layer_control[layer_idx][7:0];
      ADDR_WININ_0:   rd_mux = {2'd0, window_layer_mask[0]};
      ADDR_WININ_1:   rd_mux = {2'd0, window_layer_mask[1]};
      ADDR_WINOUT:    rd_mux = {2'd0, window_layer_mask[3]};
      ADDR_WINOBJ:    rd_mux = {2'd0, window_layer_mask[2]};
      ADDR_BLEND_LO:  rd_mux = blend_targets_mode[7:0];
      ADDR_BLEND_HI:  rd_mux = {2'd0, blend_targets_mode[13:8]};
      ADDR_BLEND_EVA: rd_mux = {3'd0, blend_coefficient[0]};
      ADDR_BLEND_EVB: rd_mux = {3'd0, blend_coefficient[1]};
      default:        rd_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_data <= (s1_wr == REQ_WRITE) ? 8'd0 : rd_mux;
    end
  end

  `LCDRF_ASSERT_NEXT(a_write_reads_zero, wr_commit, out_valid && read_data == 8'd0)
  `LCDRF_ASSERT_NEXT(a_vcompare_written, wr_commit && s1_addr == ADDR_VCOMPARE, vcount_compare == $past(s1_data))
  `LCDRF_ASSERT_NOW(a_no_wrap_bg01, 1'b1, !layer_control[0][13] && !layer_control[1][13])
  `LCDRF_ASSERT_NOW(a_latch_tracks, 1'b1, reference_latch[3] == reference_point[3] && reference_latch[2] == reference_point[2])
  `LCDRF_ASSERT_NOW(a_stall_cause, !in_ready, s1_valid && out_valid && !out_ready)

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for lcd_controller_register_file_unit: directed and random bus traffic,
// each transfer predicted at acceptance and compared with the returned byte.
// Depends on lcdrf_pkg and the RTL only.
module testbench;
  import lcdrf_pkg::*;

  localparam logic  REQ_READ        = ~REQ_WRITE;
  localparam byte_t ADDR_UNUSED_03  = 8'h03;
  localparam byte_t ADDR_UNUSED_55  = 8'h55;
  localparam byte_t ADDR_TOP        = 8'hFF;
  localparam int    RANDOM_ROUNDS   = 10;
  localparam int    ROUND_ACCESSES  = 100;
  localparam int    TAIL_CYCLES     = 10;
  localparam int    TIMEOUT_NS      = 2_000_000;

  typedef struct packed {
    logic  wr;
    byte_t offset;
    byte_t data;
  } bus_result_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       req_type;
  logic [7:0] addr_offset;
  logic [7:0] write_data;
  logic       in_vblank;
  logic       in_hblank;
  logic       line_match;
  logic [7:0] line_count;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_data;

  // predicted register contents
  logic [15:0] disp_ctl;
  logic        win_out_en;
  logic        green_swap;
  logic [2:0]  stat_irq_en;
  logic [7:0]  vcmp;
  logic [15:0] bg_ctl [4];
  logic [8:0]  bg_scroll [8];
  logic [15:0] bg_affine [8];
  logic [27:0] bg_ref [4];
  logic [27:0] bg_ref_latch [4];
  logic [7:0]  win_bound [8];
  logic [5:0]  win_mask [4];
  logic [3:0]  mosaic [4];
  logic [13:0] blend_ctl;
  logic [4:0]  blend_coef [3];

  bus_result_t expected_bytes [$];
  int unsigned mismatches;
  int unsigned accesses_sent;
  logic        back_to_back;

  lcd_controller_register_file_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .addr_offset (addr_offset),
    .write_data  (write_data),
    .in_vblank   (in_vblank),
    .in_hblank   (in_hblank),
    .line_match  (line_match),
    .line_count  (line_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  task automatic clear_registers();
    disp_ctl    = '0;
    win_out_en  = 1'b0;
    green_swap  = 1'b0;
    stat_irq_en = '0;
    vcmp        = '0;
    blend_ctl   = '0;
    for (int i = 0; i < 8; i++) begin
      bg_scroll[i] = '0;
      bg_affine[i] = '0;
      win_bound[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      bg_ctl[i]       = '0;
      bg_ref[i]       = '0;
      bg_ref_latch[i] = '0;
      win_mask[i]     = '0;
      mosaic[i]       = '0;
    end
    for (int i = 0; i < 3; i++) blend_coef[i] = '0;
  endtask

  function automatic void write_ref_byte(int unsigned idx, logic [1:0] sel, byte_t d);
    // top byte only holds bits 24..27; the latch always tracks the whole point
    if (sel == 2'd3) bg_ref[idx][27:24] = d[3:0];
    else bg_ref[idx][sel*8 +: 8] = d;
    bg_ref_latch[idx] = bg_ref[idx];
  endfunction

  // Applies one access to the predicted registers and returns the byte the bus should see.
  function automatic byte_t apply_access(logic wr, byte_t a, byte_t d, logic vb, logic hb,
                                         logic lm, byte_t lc);
    int unsigned i;
    byte_t       rd;
    rd = '0;
    if (wr == REQ_WRITE) begin
      if (a == ADDR_DISPCNT_LO) disp_ctl[7:0] = d;
      else if (a == ADDR_DISPCNT_HI) begin
        disp_ctl[15:8] = d;
        win_out_en = |d[7:5];
      end else if (a == ADDR_GREEN_SWAP) green_swap = d[0];
      else if (a == ADDR_DISPSTAT) stat_irq_en = d[5:3];
      else if (a == ADDR_VCOMPARE) vcmp = d;
      else if (a >= ADDR_BGCNT_FIRST && a <= ADDR_BGCNT_LAST) begin
        i = (a - ADDR_BGCNT_FIRST) >> 1;
        if (a[0]) bg_ctl[i][15:8] = d;
        else bg_ctl[i][7:0] = d;
        if (i < 2) bg_ctl[i][13] = 1'b0;  // no wrap on the text layers
      end else if (a >= ADDR_SCROLL_FIRST && a <= ADDR_SCROLL_LAST) begin
        i = (a - ADDR_SCROLL_FIRST) >> 1;
        if (a[0]) bg_scroll[i][8] = d[0];
        else bg_scroll[i][7:0] = d;
      end else if (a >= ADDR_AFF2_FIRST && a <= ADDR_AFF2_LAST) begin
        i = (a - ADDR_AFF2_FIRST) >> 1;
        if (a[0]) bg_affine[i][15:8] = d;
        else bg_affine[i][7:0] = d;
      end else if (a >= ADDR_AFF3_FIRST && a <= ADDR_AFF3_LAST) begin
        i = 4 + ((a - ADDR_AFF3_FIRST) >> 1);
        if (a[0]) bg_affine[i][15:8] = d;
        else bg_affine[i][7:0] = d;
      end else if (a >= ADDR_REF2_FIRST && a <= ADDR_REF2_LAST)
        write_ref_byte((a - ADDR_REF2_FIRST) >> 2, a[1:0], d);
      else if (a >= ADDR_REF3_FIRST && a <= ADDR_REF3_LAST)
        write_ref_byte(2 + ((a - ADDR_REF3_FIRST) >> 2), a[1:0], d);
      else if (a >= ADDR_WINBND_FIRST && a <= ADDR_WINBND_LAST)
        win_bound[a - ADDR_WINBND_FIRST] = d;
      else if (a == ADDR_WININ_0) win_mask[0] = d[5:0];
      else if (a == ADDR_WININ_1) win_mask[1] = d[5:0];
      else if (a == ADDR_WINOUT) win_mask[3] = d[5:0];
      else if (a == ADDR_WINOBJ) win_mask[2] = d[5:0];
      else if (a == ADDR_MOSAIC_LO) begin
        mosaic[0] = d[3:0];
        mosaic[1] = d[7:4];
      end else if (a == ADDR_MOSAIC_HI) begin
        mosaic[2] = d[3:0];
        mosaic[3] = d[7:4];
      end else if (a == ADDR_BLEND_LO) blend_ctl[7:0] = d;
      else if (a == ADDR_BLEND_HI) blend_ctl[13:8] = d[5:0];
      else if (a >= ADDR_BLEND_EVA && a <= ADDR_BLEND_EVY)
        blend_coef[a - ADDR_BLEND_EVA] = d[4:0];
    end else begin
      if (a == ADDR_DISPCNT_LO) rd = disp_ctl[7:0];
      else if (a == ADDR_DISPCNT_HI) rd = disp_ctl[15:8];
      else if (a == ADDR_GREEN_SWAP) rd = {7'd0, green_swap};
      else if (a == ADDR_DISPSTAT) rd = {2'd0, stat_irq_en, lm, hb, vb};
      else if (a == ADDR_VCOMPARE) rd = vcmp;
      else if (a == ADDR_VCOUNT) rd = lc;
      else if (a >= ADDR_BGCNT_FIRST && a <= ADDR_BGCNT_LAST) begin
        i = (a - ADDR_BGCNT_FIRST) >> 1;
        rd = a[0] ? bg_ctl[i][15:8] : bg_ctl[i][7:0];
      end else if (a == ADDR_WININ_0) rd = {2'd0, win_mask[0]};
      else if (a == ADDR_WININ_1) rd = {2'd0, win_mask[1]};
      else if (a == ADDR_WINOUT) rd = {2'd0, win_mask[3]};
      else if (a == ADDR_WINOBJ) rd = {2'd0, win_mask[2]};
      else if (a == ADDR_BLEND_LO) rd = blend_ctl[7:0];
      else if (a == ADDR_BLEND_HI) rd = {2'd0, blend_ctl[13:8]};
      else if (a == ADDR_BLEND_EVA) rd = {3'd0, blend_coef[0]};
      else if (a == ADDR_BLEND_EVB) rd = {3'd0, blend_coef[1]};
    end
    return rd;
  endfunction

  // Predict on every request transfer, check on every result transfer.
  always @(posedge clk) begin : monitor
    bus_result_t item;
    bus_result_t want;
    if (!rst && in_valid && in_ready) begin
      item.wr     = req_type;
      item.offset = addr_offset;
      item.data   = apply_access(req_type, addr_offset, write_data, in_vblank, in_hblank,
                                 line_match, line_count);
      expected_bytes.push_back(item);
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, nothing outstanding: actual 0x%h", $time, read_data);
      end else begin
        want = expected_bytes.pop_front();
        if (read_data !== want.data) begin
          mismatches++;
          $display("%0t: read_data for %s at offset 0x%h: expected 0x%h, actual 0x%h", $time,
                   (want.wr == REQ_WRITE) ? "write" : "read", want.offset, want.data,
                   read_data);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (back_to_back || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: bursts of ready broken by stalls of random length.
  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with valid possibly still high.
  task automatic send_access(input logic wr, input byte_t addr, input byte_t data,
                             input logic [2:0] live, input byte_t line);
    int unsigned gap;
    req_type    <= wr;
    addr_offset <= addr;
    write_data  <= data;
    in_vblank   <= live[0];
    in_hblank   <= live[1];
    line_match  <= live[2];
    line_count  <= line;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accesses_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic test_display_control();
    send_access(REQ_WRITE, ADDR_DISPCNT_LO, 8'hFF, 3'b000, 8'h00);
    send_access(REQ_WRITE, ADDR_DISPCNT_HI, 8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_DISPCNT_LO, 8'h00, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_DISPCNT_HI, 8'h00, 3'b000, 8'h00);
    send_access(REQ_WRITE, ADDR_GREEN_SWAP, 8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_GREEN_SWAP, 8'h00, 3'b000, 8'h00);
  endtask

  task automatic test_status_and_vcount();
    // low status bits must stay live, not take the written ones
    send_access(REQ_WRITE, ADDR_DISPSTAT, 8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_DISPSTAT, 8'h00, 3'b111, 8'h00);
    send_access(REQ_WRITE, ADDR_VCOMPARE, 8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_VCOMPARE, 8'h00, 3'b000, 8'h00);
    send_access(REQ_WRITE, ADDR_VCOUNT,   8'hA5, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_VCOUNT,   8'h00, 3'b010, 8'hFF);
  endtask

  task automatic test_layer_control();
    send_access(REQ_WRITE, ADDR_BGCNT_FIRST + 8'd1, 8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_BGCNT_FIRST + 8'd1, 8'h00, 3'b000, 8'h00);
    send_access(REQ_WRITE, ADDR_BGCNT_LAST - 8'd2,  8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_BGCNT_LAST - 8'd2,  8'h00, 3'b000, 8'h00);
  endtask

  task automatic test_write_only();
    send_access(REQ_WRITE, ADDR_REF2_FIRST + 8'd3, 8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_REF2_FIRST + 8'd3, 8'h00, 3'b111, 8'hFF);
    send_access(REQ_WRITE, ADDR_BLEND_EVY, 8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_BLEND_EVY, 8'h00, 3'b000, 8'h00);
  endtask

  task automatic test_window_and_blend();
    send_access(REQ_WRITE, ADDR_WINOUT,  8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_WINOUT,  8'h00, 3'b000, 8'h00);
    send_access(REQ_WRITE, ADDR_BLEND_HI, 8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_BLEND_HI, 8'h00, 3'b000, 8'h00);
  endtask

  task automatic test_unmapped();
    send_access(REQ_WRITE, ADDR_UNUSED_55, 8'hFF, 3'b000, 8'h00);
    send_access(REQ_READ,  ADDR_UNUSED_55, 8'h00, 3'b111, 8'hFF);
    send_access(REQ_READ,  ADDR_TOP,       8'h00, 3'b111, 8'hFF);
    send_access(REQ_READ,  ADDR_UNUSED_03, 8'h00, 3'b111, 8'hFF);
  endtask

  function automatic byte_t pick_readable();
    case ($urandom_range(0, 14))
      0:       return ADDR_DISPCNT_LO;
      1:       return ADDR_DISPCNT_HI;
      2:       return ADDR_GREEN_SWAP;
      3:       return ADDR_DISPSTAT;
      4:       return ADDR_VCOMPARE;
      5:       return ADDR_VCOUNT;
      6:       return ADDR_WININ_0;
      7:       return ADDR_WININ_1;
      8:       return ADDR_WINOUT;
      9:       return ADDR_WINOBJ;
      10:      return ADDR_BLEND_LO;
      11:      return ADDR_BLEND_HI;
      12:      return ADDR_BLEND_EVA;
      13:      return ADDR_BLEND_EVB;
      default: return byte_t'(ADDR_BGCNT_FIRST + $urandom_range(0, 7));
    endcase
  endfunction

  // Mostly write-then-read pairs so stored fields get read back; the rest is loose traffic.
  task automatic test_random_traffic();
    int unsigned round_start;
    int unsigned kind;
    byte_t       a;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      back_to_back = ($urandom_range(0, 3) == 0);
      round_start  = accesses_sent;
      while (accesses_sent - round_start < ROUND_ACCESSES) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          a = $urandom_range(0, 1) ? pick_readable()
                                   : byte_t'($urandom_range(0, ADDR_BLEND_EVY + 1));
          send_access(REQ_WRITE, a, byte_t'($urandom_range(0, 255)),
                      3'($urandom_range(0, 7)), byte_t'($urandom_range(0, 255)));
          send_access(REQ_READ, a, byte_t'($urandom_range(0, 255)),
                      3'($urandom_range(0, 7)), byte_t'($urandom_range(0, 255)));
        end else begin
          a = (kind < 85) ? byte_t'($urandom_range(0, ADDR_BLEND_EVY + 1))
                          : byte_t'($urandom_range(0, 255));
          send_access(logic'($urandom_range(0, 1)), a, byte_t'($urandom_range(0, 255)),
                      3'($urandom_range(0, 7)), byte_t'($urandom_range(0, 255)));
        end
      end
      if (round == RANDOM_ROUNDS / 2) wait_for_results();
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    req_type      = REQ_READ;
    addr_offset   = '0;
    write_data    = '0;
    in_vblank     = 1'b0;
    in_hblank     = 1'b0;
    line_match    = 1'b0;
    line_count    = '0;
    mismatches    = 0;
    accesses_sent = 0;
    back_to_back  = 1'b0;
    clear_registers();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_display_control();
    test_status_and_vcount();
    wait_for_results();
    test_layer_control();
    test_write_only();
    test_window_and_blend();
    test_unmapped();
    test_random_traffic();

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
